>>> rtl/core/dtf_pkg.sv
// Shared types and constants of the degenerate triangle filter.
package dtf_pkg;

  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int COORD_WIDTH_DEF  = 16;

  localparam int COUNT_W  = 13;
  localparam int THRESH_W = 63;
  localparam int INDEX_W  = 32;
  localparam int FIELD_W  = 16;
  localparam int SLOT_W   = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 63'd4295;

  localparam logic [1:0] VERDICT_KEPT   = 2'd0;
  localparam logic [1:0] VERDICT_RANGE  = 2'd1;
  localparam logic [1:0] VERDICT_DUP    = 2'd2;
  localparam logic [1:0] VERDICT_FLAT   = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]  vertex_count;
    logic [THRESH_W-1:0] flat_threshold;
  } dtf_cfg_t;

endpackage

>>> rtl/core/dtf_cfg_regs.sv
// APB register file holding the vertex count and the flatness threshold.
module dtf_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output dtf_pkg::dtf_cfg_t cfg
);
  import dtf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Registers sit at 8-byte spacing; address bit 3 picks the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vertex_count   <= '0;
      cfg.flat_threshold <= THRESH_RESET;
    end else if (wr_en) begin
      if (paddr[3]) begin
        cfg.flat_threshold <= pwdata[THRESH_W-1:0];
      end else begin
        cfg.vertex_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3]) begin
      prdata = {{(64-THRESH_W){1'b0}}, cfg.flat_threshold};
    end else begin
      prdata = {{(64-COUNT_W){1'b0}}, cfg.vertex_count};
    end
  end

endmodule

>>> rtl/core/dtf_vertex_ram.sv
// Single-port vertex position memory with a registered read port.
module dtf_vertex_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 48,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/dtf_flat_unit.sv
// Seven-stage pipeline computing the squared cross length and the flat test.
module dtf_flat_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [3*COORD_WIDTH-1:0]          va,
  input  logic [3*COORD_WIDTH-1:0]          vb,
  input  logic [3*COORD_WIDTH-1:0]          vc,
  input  logic [dtf_pkg::THRESH_W-1:0]      threshold,
  output logic                              done,
  output logic                              flat
);
  import dtf_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * DW;
  localparam int MW   = PW + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int HW   = MW - H;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > THRESH_W) ? SUMW : THRESH_W;

  logic [6:0] vld;

  logic signed [DW-1:0] ab [3];
  logic signed [DW-1:0] ac [3];
  logic signed [PW-1:0] prod [6];
  logic signed [MW-1:0] crs [3];
  logic [MW-1:0]        mag [3];
  logic [2*HW-1:0]      p_hh [3];
  logic [2*H-1:0]       p_ll [3];
  logic [MW-1:0]        p_hl [3];
  logic [SQW-1:0]       sq [3];
  logic [CMPW-1:0]      total;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], start};
    end
  end

  assign done = vld[6];

  always_ff @(posedge clk) begin
    // Edge vectors relative to corner a; lane 0 is x, 1 is y, 2 is z.
    for (int k = 0; k < 3; k++) begin
      ab[k] <= DW'(signed'(vb[k*W +: W])) - DW'(signed'(va[k*W +: W]));
      ac[k] <= DW'(signed'(vc[k*W +: W])) - DW'(signed'(va[k*W +: W]));
    end

    prod[0] <= PW'(ab[1]) * PW'(ac[2]);
    prod[1] <= PW'(ab[2]) * PW'(ac[1]);
    prod[2] <= PW'(ab[2]) * PW'(ac[0]);
    prod[3] <= PW'(ab[0]) * PW'(ac[2]);
    prod[4] <= PW'(ab[0]) * PW'(ac[1]);
    prod[5] <= PW'(ab[1]) * PW'(ac[0]);

    for (int k = 0; k < 3; k++) begin
      crs[k] <= MW'(prod[2*k]) - MW'(prod[2*k+1]);
      mag[k] <= crs[k][MW-1] ? MW'(-crs[k]) : MW'(crs[k]);
      // Square of the magnitude split into high and low halves.
      p_hh[k] <= (2*HW)'(mag[k][MW-1:H]) * (2*HW)'(mag[k][MW-1:H]);
      p_ll[k] <= (2*H)'(mag[k][H-1:0]) * (2*H)'(mag[k][H-1:0]);
      p_hl[k] <= MW'(mag[k][MW-1:H]) * MW'(mag[k][H-1:0]);
      sq[k]   <= (SQW'(p_hh[k]) << (2*H)) + (SQW'(p_hl[k]) << (H+1)) + SQW'(p_ll[k]);
    end
  end

  assign total = CMPW'(sq[0]) + CMPW'(sq[1]) + CMPW'(sq[2]);

  always_ff @(posedge clk) begin
    if (vld[5]) begin
      flat <= (total <= CMPW'(threshold));
    end
  end

endmodule

>>> rtl/core/degenerate_triangle_filter.sv
// Top level of the degenerate triangle filter: stream ports, sequencer and output register.
//
// The input stream carries two kinds of beat, told apart by s_tuser. A load beat
// (s_tuser = 0) writes one vertex position into the vertex memory and is finished in
// the cycle it is accepted. A check beat (s_tuser = 1) carries three vertex indices
// and yields exactly one result beat on the output stream with a keep flag, a verdict
// and the three indices passed through.
// A check beat whose indices are out of range or repeat is judged at once. Any other
// check beat reads its three corners one per cycle from the single-port vertex
// memory, then runs the seven-stage flatness pipeline. The next beat can be accepted
// in the same cycle in which the result of a check beat appears on the output stream.
// One beat is worked on at a time. A finished result waits in the output register
// while the next beat is already accepted; only a second result finding that register
// still full holds the sequencer until the receiver takes the first.
// The APB port writes the vertex count and the flat threshold; write it only while
// no check beat is in flight. Synchronous reset empties the output register,
// returns the sequencer to idle and restores the register defaults. The vertex
// memory is not cleared: only entries that were loaded may be referenced.
module degenerate_triangle_filter #(
  parameter int VERTEX_DEPTH = dtf_pkg::VERTEX_DEPTH_DEF,
  parameter int COORD_WIDTH  = dtf_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata fields from bit 0: load_slot[11:0], pos_x[27:12], pos_y[43:28],
  // pos_z[59:44], corner_a[91:60], corner_b[123:92], corner_c[155:124], zero fill.
  input  logic [159:0] s_tdata,
  // s_tuser fields from bit 0: mode.
  input  logic         s_tuser,
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata fields from bit 0: out_a[31:0], out_b[63:32], out_c[95:64].
  output logic [95:0]  m_tdata,
  // m_tuser fields from bit 0: keep[0], verdict[2:1].
  output logic [2:0]   m_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import dtf_pkg::*;

  localparam int AW    = $clog2(VERTEX_DEPTH);
  localparam int VW    = 3 * COORD_WIDTH;
  localparam int SLOTX = 17;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD_A   = 3'd1;
  localparam logic [2:0] ST_RD_B   = 3'd2;
  localparam logic [2:0] ST_RD_C   = 3'd3;
  localparam logic [2:0] ST_LAST   = 3'd4;
  localparam logic [2:0] ST_CALC   = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  dtf_cfg_t cfg;

  logic [2:0] state;
  logic [2:0] state_next;

  logic                in_fire;
  logic                mode;
  logic [SLOT_W-1:0]   load_slot;
  logic [FIELD_W-1:0]  pos_x, pos_y, pos_z;
  logic [INDEX_W-1:0]  corner_a, corner_b, corner_c;
  logic [SLOTX-1:0]    slot_ext;
  logic [INDEX_W-1:0]  limit;
  logic                bad_range, bad_dup;

  logic [INDEX_W-1:0]  idx_a, idx_b, idx_c;
  logic [1:0]          verdict;
  logic [VW-1:0]       va, vb;

  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [VW-1:0]       mem_wdata;
  logic [VW-1:0]       mem_rdata;
  logic [31:0]         wx, wy, wz;

  logic                flat_start, flat_done, flat;
  logic                out_free, out_load;

  assign load_slot = s_tdata[11:0];
  assign pos_x     = s_tdata[27:12];
  assign pos_y     = s_tdata[43:28];
  assign pos_z     = s_tdata[59:44];
  assign corner_a  = s_tdata[91:60];
  assign corner_b  = s_tdata[123:92];
  assign corner_c  = s_tdata[155:124];
  assign mode      = s_tuser;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  dtf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The effective vertex count never exceeds the memory depth.
  assign limit = (INDEX_W'(cfg.vertex_count) > INDEX_W'(VERTEX_DEPTH)) ?
                 INDEX_W'(VERTEX_DEPTH) : INDEX_W'(cfg.vertex_count);
  assign bad_range = (corner_a >= limit) || (corner_b >= limit) || (corner_c >= limit);
  assign bad_dup   = (corner_a == corner_b) || (corner_b == corner_c) ||
                     (corner_a == corner_c);

  // Coordinates keep their low COORD_WIDTH bits; wider stores see the field
  // zero-extended, exactly as the bits arrive.
  assign wx        = {16'b0, pos_x};
  assign wy        = {16'b0, pos_y};
  assign wz        = {16'b0, pos_z};
  assign mem_wdata = {wz[COORD_WIDTH-1:0], wy[COORD_WIDTH-1:0], wx[COORD_WIDTH-1:0]};
  assign slot_ext  = SLOTX'(load_slot);

  // Loads beyond the memory depth are dropped.
  assign mem_we = in_fire && !mode && (slot_ext < SLOTX'(VERTEX_DEPTH));

  always_comb begin
    case (state)
      ST_RD_A: mem_addr = idx_a[AW-1:0];
      ST_RD_B: mem_addr = idx_b[AW-1:0];
      ST_RD_C: mem_addr = idx_c[AW-1:0];
      default: mem_addr = slot_ext[AW-1:0];
    endcase
  end

  dtf_vertex_ram #(
    .DEPTH (VERTEX_DEPTH),
    .WIDTH (VW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // The read data is registered, so corner a lands during RD_B.
  always_ff @(posedge clk) begin
    if (state == ST_RD_B) begin
      va <= mem_rdata;
    end
    if (state == ST_RD_C) begin
      vb <= mem_rdata;
    end
  end

  assign flat_start = (state == ST_LAST);

  dtf_flat_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_flat (
    .clk       (clk),
    .rst       (rst),
    .start     (flat_start),
    .va        (va),
    .vb        (vb),
    .vc        (mem_rdata),
    .threshold (cfg.flat_threshold),
    .done      (flat_done),
    .flat      (flat)
  );

  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == ST_CALC) && flat_done && out_free) ||
                    ((state == ST_RESULT) && out_free);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && mode) begin
          state_next = (bad_range || bad_dup) ? ST_RESULT : ST_RD_A;
        end
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_RD_C;
      ST_RD_C: state_next = ST_LAST;
      ST_LAST: state_next = ST_CALC;
      ST_CALC: begin
        if (flat_done) begin
          state_next = out_free ? ST_IDLE : ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Indices and the early verdict are captured with the check beat.
  always_ff @(posedge clk) begin
    if (in_fire && mode) begin
      idx_a <= corner_a;
      idx_b <= corner_b;
      idx_c <= corner_c;
      if (bad_range) begin
        verdict <= VERDICT_RANGE;
      end else if (bad_dup) begin
        verdict <= VERDICT_DUP;
      end else begin
        verdict <= VERDICT_KEPT;
      end
    end else if ((state == ST_CALC) && flat_done) begin
      verdict <= flat ? VERDICT_FLAT : VERDICT_KEPT;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {idx_c, idx_b, idx_a};
      if (state == ST_CALC) begin
        m_tuser <= flat ? {VERDICT_FLAT, 1'b0} : {VERDICT_KEPT, 1'b1};
      end else begin
        m_tuser <= {verdict, (verdict == VERDICT_KEPT)};
      end
    end
  end

  // A check beat closes the input until its result has been loaded into the output register.
  a_check_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("input accepted while a check was in flight");

  // The flatness pipeline only finishes while the sequencer waits for it.
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    flat_done |-> (state == ST_CALC))
    else $error("flat unit finished outside the calculation state");

  // The memory is written only from idle, never during a corner read.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE))
    else $error("vertex memory written during a check");

  // The keep flag of a result agrees with its verdict.
  a_keep_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == VERDICT_KEPT)))
    else $error("keep flag disagrees with verdict");

endmodule
